/* rtl/core/dual_relay_thermostat_defines.svh */
// ----------------------------------------------------------------------------
// dual_relay_thermostat_defines.svh
// Assertion macros shared by the thermostat RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_RELAY_THERMOSTAT_DEFINES_SVH
`define DUAL_RELAY_THERMOSTAT_DEFINES_SVH

`ifndef SYNTHESIS

// check that the consequent holds in the same cycle as the antecedent
`define DRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that the consequent holds in the cycle after the antecedent
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Types, register indexes and defaults of the dual relay thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

	// default build values
	localparam int DefActiveLow = 1;
	localparam int DefNumRelays = 2;
	localparam int DefHysteresis = 8;

	localparam int TempW = 12;
	localparam int CfgIdxW = 3;
	localparam int MaxRelays = 2;
	localparam int NumSensors = 4;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_OUTDOOR_ENABLE = 3'd0,
		CFG_OUTDOOR_MIN    = 3'd1,
		CFG_RELAY_MODES    = 3'd2,
		CFG_SENSOR_SELECT  = 3'd3,
		CFG_RELAY0_ON      = 3'd4,
		CFG_RELAY0_OFF     = 3'd5,
		CFG_RELAY1_ON      = 3'd6,
		CFG_RELAY1_OFF     = 3'd7
	} cfg_index_t;

	// per-relay operating mode
	typedef enum logic [1:0] {
		MODE_THERMOSTAT = 2'd0,
		MODE_FORCED_ON  = 2'd1,
		MODE_FORCED_OFF = 2'd2,
		MODE_BAND       = 2'd3
	} relay_mode_t;

	typedef logic signed [TempW-1:0] temp_t;

	// one sensor tick
	typedef struct packed {
		temp_t sensor_temp_0;
		logic  sensor_valid_0;
		temp_t sensor_temp_1;
		logic  sensor_valid_1;
		temp_t sensor_temp_2;
		logic  sensor_valid_2;
		temp_t sensor_temp_3;
		logic  sensor_valid_3;
		temp_t outdoor_temp;
		logic  outdoor_valid;
	} tick_t;

	// one relay result
	typedef struct packed {
		logic relay0_active;
		logic relay1_active;
		logic relay0_level;
		logic relay1_level;
		logic blocked;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/dual_relay_thermostat.sv */
// ----------------------------------------------------------------------------
// dual_relay_thermostat
// Two-relay hysteresis thermostat with cold-outdoor blocking.
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  tick      tick_valid / tick_stall      drt_pkg::tick_t (4 sensors, outdoor)
//  result    result_valid / result_stall  drt_pkg::result_t (relays, blocked)
//  cfg       cfg_valid / cfg_ready        cfg_index (3 bit), cfg_data (12 bit)
//
//  One tick per cycle sustained while the result is not stalled; a taken tick
//  sits in the input register, then moves on to the result register, from
//  which it is offered as a result.
//  The relay state bits update in the cycle a tick moves into the result
//  register, so the next tick sees them with no bubble.
//  Reset clears the config registers and both relay states (relays off).
//  A stalled result holds the result register and, through it, the input
//  register; tick_stall rises only when both are full and result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_relay_thermostat_defines.svh"

module dual_relay_thermostat #(
	parameter int ACTIVE_LOW = drt_pkg::DefActiveLow,
	parameter int NUM_RELAYS = drt_pkg::DefNumRelays,
	parameter int HYSTERESIS = drt_pkg::DefHysteresis
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick_valid,
	output logic                               tick_stall,
	input  wire drt_pkg::tick_t                tick,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output drt_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [drt_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [drt_pkg::TempW-1:0]     cfg_data
);

	localparam int WideW = drt_pkg::TempW + 2;
	localparam logic signed [WideW-1:0] HystW = WideW'(HYSTERESIS);
	localparam logic LevelFlip = (ACTIVE_LOW != 0);

	// configuration registers
	logic                  outdoor_enable_q;
	drt_pkg::temp_t        outdoor_min_q;
	logic [3:0]            relay_modes_q;
	logic [3:0]            sensor_select_q;
	drt_pkg::temp_t        on_temp_q  [drt_pkg::MaxRelays];
	drt_pkg::temp_t        off_temp_q [drt_pkg::MaxRelays];

	// relay state
	logic [drt_pkg::MaxRelays-1:0] relay_q;
	logic [drt_pkg::MaxRelays-1:0] relay_nxt;

	// pipeline
	drt_pkg::tick_t   tick_s1;
	logic             valid_s1;
	drt_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;
	logic             take;
	logic             blocked;

	drt_pkg::temp_t temps  [drt_pkg::NumSensors];
	logic [drt_pkg::NumSensors-1:0] valids;

	// handshakes
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign tick_stall = valid_s1 && !advance;
	assign take       = tick_valid && !tick_stall;
	assign cfg_ready  = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outdoor_enable_q <= 1'b0;
			outdoor_min_q    <= '0;
			relay_modes_q    <= '0;
			sensor_select_q  <= '0;
			for (int i = 0; i < drt_pkg::MaxRelays; i++) begin
				on_temp_q[i]  <= '0;
				off_temp_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (drt_pkg::cfg_index_t'(cfg_index))
				drt_pkg::CFG_OUTDOOR_ENABLE: outdoor_enable_q <= cfg_data[0];
				drt_pkg::CFG_OUTDOOR_MIN:    outdoor_min_q    <= cfg_data;
				drt_pkg::CFG_RELAY_MODES:    relay_modes_q    <= cfg_data[3:0];
				drt_pkg::CFG_SENSOR_SELECT:  sensor_select_q  <= cfg_data[3:0];
				drt_pkg::CFG_RELAY0_ON:      on_temp_q[0]     <= cfg_data;
				drt_pkg::CFG_RELAY0_OFF:     off_temp_q[0]    <= cfg_data;
				drt_pkg::CFG_RELAY1_ON:      on_temp_q[1]     <= cfg_data;
				drt_pkg::CFG_RELAY1_OFF:     off_temp_q[1]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1 <= tick;
		end
	end

	// unpack sensors
	always_comb begin
		temps[0]  = tick_s1.sensor_temp_0;
		temps[1]  = tick_s1.sensor_temp_1;
		temps[2]  = tick_s1.sensor_temp_2;
		temps[3]  = tick_s1.sensor_temp_3;
		valids[0] = tick_s1.sensor_valid_0;
		valids[1] = tick_s1.sensor_valid_1;
		valids[2] = tick_s1.sensor_valid_2;
		valids[3] = tick_s1.sensor_valid_3;
	end

	// cold-outdoor block
	assign blocked = outdoor_enable_q && tick_s1.outdoor_valid
		&& (tick_s1.outdoor_temp < outdoor_min_q);

	// next relay states
	always_comb begin
		drt_pkg::relay_mode_t mode;
		logic [1:0] sel;
		logic signed [WideW-1:0] t_w;
		logic signed [WideW-1:0] on_w;
		logic signed [WideW-1:0] off_w;
		logic signed [WideW-1:0] lo_w;
		logic signed [WideW-1:0] hi_w;

		relay_nxt = relay_q;
		for (int r = 0; r < drt_pkg::MaxRelays; r++) begin
			mode  = drt_pkg::relay_mode_t'(relay_modes_q[2*r +: 2]);
			sel   = sensor_select_q[2*r +: 2];
			t_w   = WideW'(temps[sel]);
			on_w  = WideW'(on_temp_q[r]);
			off_w = WideW'(off_temp_q[r]);
			lo_w  = (on_w < off_w) ? on_w : off_w;
			hi_w  = (on_w < off_w) ? off_w : on_w;
			if (r >= NUM_RELAYS || blocked) begin
				relay_nxt[r] = 1'b0;
			end else begin
				case (mode)
					drt_pkg::MODE_FORCED_ON:  relay_nxt[r] = 1'b1;
					drt_pkg::MODE_FORCED_OFF: relay_nxt[r] = 1'b0;
					drt_pkg::MODE_BAND: begin
						if (valids[sel]) begin
							if (t_w > lo_w + HystW && t_w < hi_w - HystW) begin
								relay_nxt[r] = 1'b1;
							end else if (t_w < lo_w || t_w > hi_w) begin
								relay_nxt[r] = 1'b0;
							end
						end
					end
					default: begin
						if (valids[sel]) begin
							if (on_w > off_w) begin
								if (t_w >= on_w) begin
									relay_nxt[r] = 1'b1;
								end else if (t_w <= off_w) begin
									relay_nxt[r] = 1'b0;
								end
							end else begin
								if (t_w <= on_w) begin
									relay_nxt[r] = 1'b1;
								end else if (t_w >= off_w) begin
									relay_nxt[r] = 1'b0;
								end
							end
						end
					end
				endcase
			end
		end
	end

	// advance relay state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			relay_q  <= relay_nxt;
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.relay0_active <= relay_nxt[0];
			result_s2.relay1_active <= relay_nxt[1];
			result_s2.relay0_level  <= relay_nxt[0] ^ LevelFlip;
			result_s2.relay1_level  <= relay_nxt[1] ^ LevelFlip;
			result_s2.blocked       <= blocked;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// checks
	`DRT_ASSERT_SAME(a_blocked_off, clk, arst_n, result_valid && result.blocked,
		!result.relay0_active && !result.relay1_active, "blocked result with a relay on")
	`DRT_ASSERT_NEXT(a_state_matches, clk, arst_n, advance,
		result.relay0_active == relay_q[0] && result.relay1_active == relay_q[1],
		"result disagrees with relay state")
	`DRT_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, result_valid,
		"advanced tick missing from result")
	`DRT_ASSERT_SAME(a_unused_relay, clk, arst_n, NUM_RELAYS < 2, !relay_q[1],
		"unused relay switched on")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual relay thermostat. Sends sensor ticks
// (directed corner cases, then random ticks aimed near the programmed
// thresholds) under several idle and stall profiles, tracks the relay states
// alongside the block and compares every result word field by field.
// ----------------------------------------------------------------------------

module tb;

	localparam int HalfPeriod = 5;
	localparam int QuietLimit = 4000;
	localparam int TicksPerPhase = 50;

	// relay state tracker and queue of predicted result words
	class relay_tracker;
		bit                 block_en;
		drt_pkg::temp_t     outdoor_min;
		logic [3:0]         modes;
		logic [3:0]         sel;
		drt_pkg::temp_t     on_temp[drt_pkg::MaxRelays];
		drt_pkg::temp_t     off_temp[drt_pkg::MaxRelays];
		bit                 relay_on[drt_pkg::MaxRelays];
		drt_pkg::result_t   pending_outputs[$];
		int                 fails;

		function new();
			block_en = 1'b0;
			outdoor_min = '0;
			modes = '0;
			sel = '0;
			fails = 0;
			for (int i = 0; i < drt_pkg::MaxRelays; i++) begin
				on_temp[i] = '0;
				off_temp[i] = '0;
				relay_on[i] = 1'b0;
			end
		endfunction

		// mirror a register write
		function void store_reg(drt_pkg::cfg_index_t idx, logic [drt_pkg::TempW-1:0] d);
			case (idx)
				drt_pkg::CFG_OUTDOOR_ENABLE: block_en = d[0];
				drt_pkg::CFG_OUTDOOR_MIN:    outdoor_min = d;
				drt_pkg::CFG_RELAY_MODES:    modes = d[3:0];
				drt_pkg::CFG_SENSOR_SELECT:  sel = d[3:0];
				drt_pkg::CFG_RELAY0_ON:      on_temp[0] = d;
				drt_pkg::CFG_RELAY0_OFF:     off_temp[0] = d;
				drt_pkg::CFG_RELAY1_ON:      on_temp[1] = d;
				drt_pkg::CFG_RELAY1_OFF:     off_temp[1] = d;
				default: ;
			endcase
		endfunction

		// advance one relay from its selected reading
		function void update_relay(int r, drt_pkg::temp_t reading, bit ok);
			drt_pkg::relay_mode_t m;
			int t, on, off, lo, hi;
			m = drt_pkg::relay_mode_t'(modes[2*r +: 2]);
			on = on_temp[r];
			off = off_temp[r];
			t = reading;
			lo = (on < off) ? on : off;
			hi = (on < off) ? off : on;
			case (m)
				drt_pkg::MODE_FORCED_ON:  relay_on[r] = 1'b1;
				drt_pkg::MODE_FORCED_OFF: relay_on[r] = 1'b0;
				drt_pkg::MODE_BAND: begin
					if (ok) begin
						if (t > lo + drt_pkg::DefHysteresis && t < hi - drt_pkg::DefHysteresis)
							relay_on[r] = 1'b1;
						else if (t < lo || t > hi)
							relay_on[r] = 1'b0;
					end
				end
				default: begin
					if (ok && on > off) begin
						if (t >= on)
							relay_on[r] = 1'b1;
						else if (t <= off)
							relay_on[r] = 1'b0;
					end else if (ok) begin
						if (t <= on)
							relay_on[r] = 1'b1;
						else if (t >= off)
							relay_on[r] = 1'b0;
					end
				end
			endcase
		endfunction

		// take an accepted tick and queue the result word it causes
		function void apply_tick(drt_pkg::tick_t w);
			drt_pkg::temp_t   temps[drt_pkg::NumSensors];
			bit               vld[drt_pkg::NumSensors];
			bit               cold;
			logic [1:0]       pick;
			drt_pkg::result_t r;
			temps[0] = w.sensor_temp_0;
			temps[1] = w.sensor_temp_1;
			temps[2] = w.sensor_temp_2;
			temps[3] = w.sensor_temp_3;
			vld[0] = w.sensor_valid_0;
			vld[1] = w.sensor_valid_1;
			vld[2] = w.sensor_valid_2;
			vld[3] = w.sensor_valid_3;
			cold = block_en && w.outdoor_valid && (w.outdoor_temp < outdoor_min);
			for (int i = 0; i < drt_pkg::MaxRelays; i++) begin
				pick = sel[2*i +: 2];
				if (i >= drt_pkg::DefNumRelays || cold)
					relay_on[i] = 1'b0;
				else
					update_relay(i, temps[pick], vld[pick]);
			end
			r.relay0_active = relay_on[0];
			r.relay1_active = relay_on[1];
			r.relay0_level = drt_pkg::DefActiveLow ? !relay_on[0] : relay_on[0];
			r.relay1_level = drt_pkg::DefActiveLow ? !relay_on[1] : relay_on[1];
			r.blocked = cold;
			pending_outputs.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("%0t ns mismatch: %s", $time, what);
			fails++;
		endtask

		task compare_bit(string name, logic got, logic want);
			if (got !== want)
				report_mismatch($sformatf("%s got %b want %b", name, got, want));
		endtask

		// match a result word against the oldest prediction
		task check_result(drt_pkg::result_t got);
			drt_pkg::result_t want;
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("result %b with nothing pending", got));
				return;
			end
			want = pending_outputs.pop_front();
			compare_bit("relay0_active", got.relay0_active, want.relay0_active);
			compare_bit("relay1_active", got.relay1_active, want.relay1_active);
			compare_bit("relay0_level", got.relay0_level, want.relay0_level);
			compare_bit("relay1_level", got.relay1_level, want.relay1_level);
			compare_bit("blocked", got.blocked, want.blocked);
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        tick_valid = 1'b0;
	logic                        tick_stall;
	drt_pkg::tick_t              tick = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	drt_pkg::result_t            result;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [drt_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [drt_pkg::TempW-1:0]   cfg_data = '0;
	int                          send_gap_pct = 0;
	int                          stall_pct = 0;
	int                          quiet_cycles = 0;
	relay_tracker                relays = new();

	dual_relay_thermostat u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HalfPeriod clk = ~clk;

	// check result words, stall at random
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			relays.check_result(result);
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_reg(drt_pkg::cfg_index_t idx, logic [drt_pkg::TempW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		relays.store_reg(idx, value);
	endtask

	// write every register; narrow ones carry random upper bits
	task automatic apply_settings(bit en, int omin, logic [3:0] modes, logic [3:0] sel,
			int on0, int off0, int on1, int off1);
		logic [drt_pkg::TempW-1:0] junk;
		junk = drt_pkg::TempW'($urandom);
		set_reg(drt_pkg::CFG_OUTDOOR_ENABLE, {junk[drt_pkg::TempW-1:1], en});
		set_reg(drt_pkg::CFG_OUTDOOR_MIN, drt_pkg::TempW'(omin));
		set_reg(drt_pkg::CFG_RELAY_MODES, {junk[drt_pkg::TempW-1:4], modes});
		set_reg(drt_pkg::CFG_SENSOR_SELECT, {junk[drt_pkg::TempW-5:0], sel});
		set_reg(drt_pkg::CFG_RELAY0_ON, drt_pkg::TempW'(on0));
		set_reg(drt_pkg::CFG_RELAY0_OFF, drt_pkg::TempW'(off0));
		set_reg(drt_pkg::CFG_RELAY1_ON, drt_pkg::TempW'(on1));
		set_reg(drt_pkg::CFG_RELAY1_OFF, drt_pkg::TempW'(off1));
		cfg_valid <= 1'b0;
	endtask

	// offer one tick word, with an optional gap before it
	task automatic send_tick(drt_pkg::tick_t w);
		if ($urandom_range(99) < send_gap_pct) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		tick_valid <= 1'b1;
		tick <= w;
		do @(posedge clk); while (tick_stall);
		relays.apply_tick(w);
	endtask

	// drop valid and wait for the pipeline to drain
	task automatic settle();
		tick_valid <= 1'b0;
		while (relays.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all four sensors read the same value
	function automatic drt_pkg::tick_t same_temp(int v, bit ok, int od, bit odv);
		drt_pkg::tick_t w;
		w.sensor_temp_0 = drt_pkg::TempW'(v);
		w.sensor_temp_1 = drt_pkg::TempW'(v);
		w.sensor_temp_2 = drt_pkg::TempW'(v);
		w.sensor_temp_3 = drt_pkg::TempW'(v);
		w.sensor_valid_0 = ok;
		w.sensor_valid_1 = ok;
		w.sensor_valid_2 = ok;
		w.sensor_valid_3 = ok;
		w.outdoor_temp = drt_pkg::TempW'(od);
		w.outdoor_valid = odv;
		return w;
	endfunction

	// mostly near a programmed threshold, sometimes at the rails
	function automatic drt_pkg::temp_t pick_temp();
		int v;
		case ($urandom_range(9))
			0: v = -2048;
			1: v = 2047;
			2, 3, 4, 5, 6: begin
				case ($urandom_range(4))
					0: v = relays.on_temp[0];
					1: v = relays.off_temp[0];
					2: v = relays.on_temp[1];
					3: v = relays.off_temp[1];
					default: v = relays.outdoor_min;
				endcase
				v = v + $urandom_range(40) - 20;
			end
			default: v = $urandom_range(4095) - 2048;
		endcase
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return drt_pkg::TempW'(v);
	endfunction

	function automatic drt_pkg::tick_t random_tick();
		drt_pkg::tick_t w;
		w.sensor_temp_0 = pick_temp();
		w.sensor_temp_1 = pick_temp();
		w.sensor_temp_2 = pick_temp();
		w.sensor_temp_3 = pick_temp();
		w.sensor_valid_0 = ($urandom_range(99) < 85);
		w.sensor_valid_1 = ($urandom_range(99) < 85);
		w.sensor_valid_2 = ($urandom_range(99) < 85);
		w.sensor_valid_3 = ($urandom_range(99) < 85);
		w.outdoor_temp = pick_temp();
		w.outdoor_valid = ($urandom_range(99) < 80);
		return w;
	endfunction

	function automatic int random_threshold(int center);
		int v;
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 2047 : -2048;
		v = center + $urandom_range(600) - 300;
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return v;
	endfunction

	// new settings for a random phase
	task automatic random_settings();
		int center, omin, on0, off0, on1, off1;
		center = $urandom_range(3000) - 1500;
		omin = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 2047 : -2048) :
			center + $urandom_range(200) - 100;
		on0 = random_threshold(center);
		off0 = ($urandom_range(9) == 0) ? on0 : random_threshold(center);
		on1 = random_threshold(center);
		off1 = ($urandom_range(9) == 0) ? on1 : random_threshold(center);
		apply_settings($urandom_range(1), omin, 4'($urandom), 4'($urandom),
			on0, off0, on1, off1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: thermostat, equal thresholds at zero, sensor 0
		send_tick(same_temp(-2048, 1'b1, 0, 1'b0));
		send_tick(same_temp(2047, 1'b1, 0, 1'b0));
		send_tick(same_temp(-2048, 1'b0, 0, 1'b0));
		send_tick(same_temp(0, 1'b1, 0, 1'b0));
		settle();

		// relay 0 window 0..320, relay 1 cooling 200/100, cold block below 100
		apply_settings(1'b1, 100, {drt_pkg::MODE_THERMOSTAT, drt_pkg::MODE_BAND},
			{2'd2, 2'd1}, 0, 320, 200, 100);
		send_tick(same_temp(-1, 1'b1, 2047, 1'b1));
		send_tick(same_temp(8, 1'b1, 2047, 1'b1));
		send_tick(same_temp(9, 1'b1, 2047, 1'b1));
		send_tick(same_temp(200, 1'b1, 2047, 1'b1));
		send_tick(same_temp(150, 1'b1, 2047, 1'b1));
		send_tick(same_temp(312, 1'b1, 2047, 1'b1));
		send_tick(same_temp(321, 1'b1, 2047, 1'b1));
		send_tick(same_temp(100, 1'b0, 2047, 1'b1));
		send_tick(same_temp(100, 1'b1, 2047, 1'b1));
		send_tick(same_temp(200, 1'b1, -2048, 1'b1));
		send_tick(same_temp(200, 1'b1, -2048, 1'b0));
		send_tick(same_temp(200, 1'b1, 99, 1'b1));
		send_tick(same_temp(200, 1'b1, 100, 1'b1));
		settle();

		// manual modes ignore the sensors; lowest block threshold never fires
		apply_settings(1'b1, -2048, {drt_pkg::MODE_FORCED_OFF, drt_pkg::MODE_FORCED_ON},
			4'b1111, -2048, 2047, 2047, -2048);
		send_tick(same_temp(-2048, 1'b0, -2048, 1'b1));
		send_tick(same_temp(2047, 1'b1, 2047, 1'b0));
		settle();

		// highest block threshold overrides manual on
		apply_settings(1'b1, 2047, {drt_pkg::MODE_FORCED_ON, drt_pkg::MODE_FORCED_OFF},
			4'b0100, 2047, -2048, -2048, 2047);
		send_tick(same_temp(0, 1'b1, 2046, 1'b1));
		send_tick(same_temp(0, 1'b1, 2047, 1'b1));
		settle();

		// random phases over the idle and stall profiles
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 51; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 51; end
				default: begin send_gap_pct = 19; stall_pct = 19; end
			endcase
			if (p == 0)
				apply_settings(1'b0, -2048,
					{drt_pkg::MODE_THERMOSTAT, drt_pkg::MODE_BAND}, 4'b0110,
					2047, -2048, -2048, 2047);
			else if (p == 5)
				apply_settings(1'b1, 2047,
					{drt_pkg::MODE_BAND, drt_pkg::MODE_THERMOSTAT}, 4'b1011,
					-2048, 2047, 2047, -2048);
			else
				random_settings();
			for (int i = 0; i < TicksPerPhase; i++)
				send_tick(random_tick());
			settle();
		end

		if (relays.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/drt_pkg.sv
rtl/core/dual_relay_thermostat.sv
tb/tb.sv
